// File: rtl/core/etrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_pkg - shared definitions for the TRS model matrix block
// Widths, command codes, fixed-point constants and the micro-op table of the
// sine/cosine sequence.
// ----------------------------------------------------------------------------
package etrs_pkg;

  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int CMD_W   = 3;

  // Wrapped angle in [0, 360.0) and the reduced octant angle in [0, 45.0].
  localparam int ANG_W = 25;
  localparam int OCT_W = 22;
  // Rotation terms stay within +-2.0.
  localparam int ROT_W = 20;
  // Series evaluation runs in unsigned Q1.30.
  localparam int Q30_W  = 31;
  localparam int Q30_SH = 30 - FRAC_W;
  localparam int TRIG_W = FRAC_W + 1;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 36;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W - FRAC_W;

  localparam logic [CMD_W-1:0] CMD_SET_POS = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_POS = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_SCL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_SCL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_ROT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ADD_ROT = 3'd5;

  localparam longint UNIT      = longint'(1) << FRAC_W;
  localparam longint FULL_L    = 360 * UNIT;
  localparam longint QUARTER_L = 90 * UNIT;

  localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(FULL_L);
  localparam logic [ANG_W-1:0] QUARTER   = ANG_W'(QUARTER_L);
  localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(2 * QUARTER_L);
  localparam logic [ANG_W-1:0] THREE_Q   = ANG_W'(3 * QUARTER_L);
  localparam logic [ANG_W-1:0] EIGHTH    = ANG_W'(45 * UNIT);
  // Residue of the sign bit weight -2^(VALUE_W-1) modulo a full turn.
  localparam logic [ANG_W-1:0] NEG_INIT =
    ANG_W'((FULL_L - ((longint'(1) << (VALUE_W - 1)) % FULL_L)) % FULL_L);

  localparam logic [MUL_B_W-1:0] DEG_RAD  = MUL_B_W'(18740330);
  localparam logic [Q30_W-1:0]   Q30_ONE  = Q30_W'(longint'(1) << 30);
  localparam logic [Q30_W-1:0]   Q30_HALF = Q30_W'((longint'(1) << Q30_SH) >> 1);

  // Reciprocals ceil(2^36 / d) give exact quotients for dividends below 2^30.
  localparam int     RECIP_SH = 36;
  localparam longint RECIP_N  = longint'(1) << RECIP_SH;
  localparam logic [MUL_B_W-1:0] RECIP_3  = MUL_B_W'((RECIP_N + 2) / 3);
  localparam logic [MUL_B_W-1:0] RECIP_5  = MUL_B_W'((RECIP_N + 4) / 5);
  localparam logic [MUL_B_W-1:0] RECIP_7  = MUL_B_W'((RECIP_N + 6) / 7);
  localparam logic [MUL_B_W-1:0] RECIP_9  = MUL_B_W'((RECIP_N + 8) / 9);
  localparam logic [MUL_B_W-1:0] RECIP_15 = MUL_B_W'((RECIP_N + 14) / 15);
  localparam logic [MUL_B_W-1:0] RECIP_21 = MUL_B_W'((RECIP_N + 20) / 21);
  localparam logic [MUL_B_W-1:0] RECIP_45 = MUL_B_W'((RECIP_N + 44) / 45);

  typedef logic signed [VALUE_W-1:0] val_t;
  typedef logic [3:0][VALUE_W-1:0]   row_t;

  localparam row_t LAST_ROW = {VALUE_W'(UNIT), {VALUE_W{1'b0}}, {VALUE_W{1'b0}},
                               {VALUE_W{1'b0}}};

  // Micro-op kinds of the series evaluation.
  localparam logic [2:0] PK_XD  = 3'd0;  // degrees to radians
  localparam logic [2:0] PK_X2  = 3'd1;  // square of the angle
  localparam logic [2:0] PK_PM  = 3'd2;  // x2 * p, then power-of-two part of divide
  localparam logic [2:0] PK_PD  = 3'd3;  // odd part of divide, p = 1 - quotient
  localparam logic [2:0] PK_PM1 = 3'd4;  // x2 * p with a pure power-of-two divisor
  localparam logic [2:0] PK_SIN = 3'd5;  // x * p gives the sine

  localparam int POLY_OPS = 20;
  localparam int MAT_OPS  = 23;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         shift;
    logic               one;
    logic [MUL_B_W-1:0] recip;
  } poly_op_t;

  function automatic poly_op_t poly_op(input logic [4:0] idx);
    poly_op_t op;
    op = '{kind: PK_XD, shift: 2'd0, one: 1'b0, recip: '0};
    case (idx)
      5'd0:  op.kind = PK_XD;
      5'd1:  op.kind = PK_X2;
      5'd2:  op = '{kind: PK_PM, shift: 2'd3, one: 1'b1, recip: '0};
      5'd3:  op = '{kind: PK_PD, shift: 2'd0, one: 1'b0, recip: RECIP_9};
      5'd4:  op = '{kind: PK_PM, shift: 2'd1, one: 1'b0, recip: '0};
      5'd5:  op = '{kind: PK_PD, shift: 2'd0, one: 1'b0, recip: RECIP_21};
      5'd6:  op = '{kind: PK_PM, shift: 2'd2, one: 1'b0, recip: '0};
      5'd7:  op = '{kind: PK_PD, shift: 2'd0, one: 1'b0, recip: RECIP_5};
      5'd8:  op = '{kind: PK_PM, shift: 2'd1, one: 1'b0, recip: '0};
      5'd9:  op = '{kind: PK_PD, shift: 2'd0, one: 1'b0, recip: RECIP_3};
      5'd10: op.kind = PK_SIN;
      5'd11: op = '{kind: PK_PM, shift: 2'd1, one: 1'b1, recip: '0};
      5'd12: op = '{kind: PK_PD, shift: 2'd0, one: 1'b0, recip: RECIP_45};
      5'd13: op = '{kind: PK_PM, shift: 2'd3, one: 1'b0, recip: '0};
      5'd14: op = '{kind: PK_PD, shift: 2'd0, one: 1'b0, recip: RECIP_7};
      5'd15: op = '{kind: PK_PM, shift: 2'd1, one: 1'b0, recip: '0};
      5'd16: op = '{kind: PK_PD, shift: 2'd0, one: 1'b0, recip: RECIP_15};
      5'd17: op = '{kind: PK_PM, shift: 2'd2, one: 1'b0, recip: '0};
      5'd18: op = '{kind: PK_PD, shift: 2'd0, one: 1'b0, recip: RECIP_3};
      5'd19: op = '{kind: PK_PM1, shift: 2'd1, one: 1'b0, recip: '0};
      default: op.kind = PK_XD;
    endcase
    return op;
  endfunction

  function automatic val_t sat_val(input logic signed [63:0] v);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    vmax = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
    vmin = -vmax - 64'sd1;
    if (v > vmax) return VALUE_W'(vmax);
    if (v < vmin) return VALUE_W'(vmin);
    return VALUE_W'(v);
  endfunction

endpackage

// File: rtl/core/etrs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_in_if - command channel
// Carries one command and a 3-vector per item.
// ----------------------------------------------------------------------------
interface etrs_in_if;
  logic                               valid;
  logic                               ready;
  logic [etrs_pkg::CMD_W-1:0]         command;
  logic signed [etrs_pkg::VALUE_W-1:0] vec_x;
  logic signed [etrs_pkg::VALUE_W-1:0] vec_y;
  logic signed [etrs_pkg::VALUE_W-1:0] vec_z;

  modport source (output valid, command, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, command, vec_x, vec_y, vec_z, output ready);
endinterface

// File: rtl/core/etrs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_out_if - matrix row channel
// Carries one row of the model matrix per item.
// ----------------------------------------------------------------------------
interface etrs_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         row_index;
  logic signed [etrs_pkg::VALUE_W-1:0] col_0;
  logic signed [etrs_pkg::VALUE_W-1:0] col_1;
  logic signed [etrs_pkg::VALUE_W-1:0] col_2;
  logic signed [etrs_pkg::VALUE_W-1:0] col_3;
  logic                               last_row;

  modport source (output valid, row_index, col_0, col_1, col_2, col_3, last_row,
                  input ready);
  modport sink (input valid, row_index, col_0, col_1, col_2, col_3, last_row,
                output ready);
endinterface

// File: rtl/core/etrs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_mul - shared signed multiplier
// One registered product per enabled cycle; used by every series and matrix step.
// ----------------------------------------------------------------------------
module etrs_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [etrs_pkg::MUL_A_W-1:0] a,
  input  logic signed [etrs_pkg::MUL_B_W-1:0] b,
  output logic signed [etrs_pkg::PROD_W-1:0]  prod
);

  logic signed [etrs_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= etrs_pkg::PROD_W'(a) * etrs_pkg::PROD_W'(b);
    end
  end

  assign prod = prod_r;

endmodule

// File: rtl/core/etrs_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_wrap - angle reduction modulo 360 degrees
// Floor modulo a full turn in one registered step, through a residue table.
// ----------------------------------------------------------------------------
module etrs_wrap (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [etrs_pkg::VALUE_W-1:0] ang,
  output logic                                done,
  output logic [etrs_pkg::ANG_W-1:0]          turn
);

  // The low part is always below a full turn, so it needs no reduction.
  localparam int LO_W = 24;
  localparam int HI_W = etrs_pkg::VALUE_W - LO_W;
  localparam int HI_N = 1 << HI_W;

  typedef logic [HI_N-1:0][etrs_pkg::ANG_W-1:0] res_tab_t;

  // Residue of each signed top-byte weight modulo a full turn.
  function automatic res_tab_t build_tab();
    res_tab_t t;
    longint   hv;
    for (int i = 0; i < HI_N; i++) begin
      hv = (i >= HI_N / 2) ? longint'(i) - longint'(HI_N) : longint'(i);
      t[i] = etrs_pkg::ANG_W'((((hv <<< LO_W) % etrs_pkg::FULL_L) + etrs_pkg::FULL_L)
                              % etrs_pkg::FULL_L);
    end
    return t;
  endfunction

  localparam res_tab_t HI_RES = build_tab();

  logic [etrs_pkg::ANG_W-1:0] hi_res;
  logic [etrs_pkg::ANG_W:0]   sum;
  logic [etrs_pkg::ANG_W-1:0] turn_nxt;
  logic [etrs_pkg::ANG_W-1:0] turn_r;
  logic                       done_r;

  // Both parts are below a full turn, so one conditional subtract finishes.
  always_comb begin
    hi_res = HI_RES[ang[etrs_pkg::VALUE_W-1 -: HI_W]];
    sum    = {1'b0, hi_res} + {{(etrs_pkg::ANG_W + 1 - LO_W){1'b0}}, ang[LO_W-1:0]};
    if (sum >= {1'b0, etrs_pkg::FULL_TURN}) begin
      sum = sum - {1'b0, etrs_pkg::FULL_TURN};
    end
    turn_nxt = sum[etrs_pkg::ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      turn_r <= '0;
    end else begin
      done_r <= start;
      if (start) begin
        turn_r <= turn_nxt;
      end
    end
  end

  assign done = done_r;
  assign turn = turn_r;

endmodule

// File: rtl/core/euler_trs_model_matrix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_trs_model_matrix_top - TRS model matrix from Euler angles
// Keeps position, scale and rotation; after each command item it rebuilds
// M = T * S * (Rz * Rx * Ry) on one shared multiplier and sends four rows.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid / ready  command, vec_x, vec_y, vec_z
//  out_ch    out  valid / ready  row_index, col_0..col_3, last_row
//
//  After an item is taken, per angle there is 1 load, 1 table-based modulo-360
//  reduction with the octant split, 20 multiplier ops and 1 finish step; then
//  23 matrix ops, after which the first row is offered. The shared multiplier
//  serialises the ops; rows follow one a cycle while out_ch.ready is high.
//  in_ch.ready is high only when idle; rows then wait for out_ch.ready.
//  Reset (rst_n, synchronous) sets position and rotation to 0, scale to 1.0.
// ----------------------------------------------------------------------------
module euler_trs_model_matrix_top (
  input logic        clk,
  input logic        rst_n,
  etrs_in_if.sink    in_ch,
  etrs_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_WRAP = 3'd2;
  localparam logic [2:0] S_POLY = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_MAT  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // Indexes of the rotation term bank.
  localparam int B_R00 = 0;
  localparam int B_R01 = 1;
  localparam int B_R02 = 2;
  localparam int B_R10 = 3;
  localparam int B_R11 = 4;
  localparam int B_R12 = 5;
  localparam int B_R20 = 6;
  localparam int B_R21 = 7;
  localparam int B_R22 = 8;
  localparam int B_SXSY = 9;
  localparam int B_SXCY = 10;
  localparam int BANK_N = 11;

  localparam logic [1:0] M_SET = 2'd0;
  localparam logic [1:0] M_NEG = 2'd1;
  localparam logic [1:0] M_ADD = 2'd2;
  localparam logic [1:0] M_SUB = 2'd3;

  localparam logic [1:0] ROW_LAST = 2'd3;
  localparam logic [1:0] ANG_LAST = 2'd2;

  typedef logic signed [etrs_pkg::ROT_W-1:0] rot_t;

  logic [2:0] state_r;
  logic [1:0] ang_r;
  logic [4:0] step_r;
  logic       ph_r;
  logic       out_valid_r;
  logic [1:0] row_r;

  etrs_pkg::val_t pos_r [3];
  etrs_pkg::val_t scl_r [3];
  etrs_pkg::val_t rot_r [3];
  etrs_pkg::val_t vec   [3];

  logic [etrs_pkg::OCT_W-1:0]  d_r;
  logic [1:0]                  quad_r;
  logic                        swap_r;
  logic [29:0]                 x_r;
  logic [29:0]                 x2_r;
  logic [29:0]                 v_r;
  logic [etrs_pkg::Q30_W-1:0]  p_r;
  logic [etrs_pkg::TRIG_W-1:0] s_oct_r;

  rot_t sin_r [3];
  rot_t cos_r [3];
  rot_t bk_r  [BANK_N];

  etrs_pkg::row_t rowbuf_r [3];

  // Shared multiplier.
  logic                                mul_en;
  logic signed [etrs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [etrs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [etrs_pkg::PROD_W-1:0]  prod;
  logic signed [etrs_pkg::PROD_W-1:0]  prod_sum;
  logic signed [etrs_pkg::RND_W-1:0]   rnd;
  rot_t                                rnd_rot;

  logic                       wrap_done;
  logic [etrs_pkg::ANG_W-1:0] turn;

  etrs_pkg::poly_op_t op;

  logic [29:0]                 t_q30;
  logic [29:0]                 t_div;
  logic [etrs_pkg::Q30_W-1:0]  sin_sum;
  logic [etrs_pkg::Q30_W-1:0]  cos_sum;
  logic [etrs_pkg::TRIG_W-1:0] c_oct;
  rot_t                        s0, c0;

  // Octant reduction of the wrapped angle.
  logic [1:0]                 quad;
  logic [etrs_pkg::ANG_W-1:0] rem;
  logic                       swap;
  logic [etrs_pkg::ANG_W-1:0] dsel;

  // Matrix step decode.
  rot_t      ma, mb;
  logic [3:0] tgt;
  logic [1:0] mode;
  rot_t       bk_new;

  assign vec[0] = in_ch.vec_x;
  assign vec[1] = in_ch.vec_y;
  assign vec[2] = in_ch.vec_z;

  etrs_wrap u_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_LOAD),
    .ang   (rot_r[ang_r]),
    .done  (wrap_done),
    .turn  (turn)
  );

  etrs_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign op = etrs_pkg::poly_op(step_r);

  always_comb begin
    if (turn >= etrs_pkg::THREE_Q) begin
      quad = 2'd3;
      rem  = turn - etrs_pkg::THREE_Q;
    end else if (turn >= etrs_pkg::HALF_TURN) begin
      quad = 2'd2;
      rem  = turn - etrs_pkg::HALF_TURN;
    end else if (turn >= etrs_pkg::QUARTER) begin
      quad = 2'd1;
      rem  = turn - etrs_pkg::QUARTER;
    end else begin
      quad = 2'd0;
      rem  = turn;
    end
    // Above 45 degrees the complement is evaluated and sine and cosine swap.
    swap = rem > etrs_pkg::EIGHTH;
    dsel = swap ? (etrs_pkg::QUARTER - rem) : rem;
  end

  always_comb begin
    ma   = '0;
    mb   = '0;
    tgt  = 4'(B_R00);
    mode = M_SET;
    case (step_r)
      5'd0:  begin ma = sin_r[0]; mb = sin_r[1]; tgt = 4'(B_SXSY); mode = M_SET; end
      5'd1:  begin ma = sin_r[0]; mb = cos_r[1]; tgt = 4'(B_SXCY); mode = M_SET; end
      5'd2:  begin ma = cos_r[2]; mb = cos_r[1]; tgt = 4'(B_R00);  mode = M_SET; end
      5'd3:  begin ma = sin_r[2]; mb = bk_r[B_SXSY]; tgt = 4'(B_R00); mode = M_SUB; end
      5'd4:  begin ma = sin_r[2]; mb = cos_r[0]; tgt = 4'(B_R01);  mode = M_NEG; end
      5'd5:  begin ma = cos_r[2]; mb = sin_r[1]; tgt = 4'(B_R02);  mode = M_SET; end
      5'd6:  begin ma = sin_r[2]; mb = bk_r[B_SXCY]; tgt = 4'(B_R02); mode = M_ADD; end
      5'd7:  begin ma = sin_r[2]; mb = cos_r[1]; tgt = 4'(B_R10);  mode = M_SET; end
      5'd8:  begin ma = cos_r[2]; mb = bk_r[B_SXSY]; tgt = 4'(B_R10); mode = M_ADD; end
      5'd9:  begin ma = cos_r[2]; mb = cos_r[0]; tgt = 4'(B_R11);  mode = M_SET; end
      5'd10: begin ma = sin_r[2]; mb = sin_r[1]; tgt = 4'(B_R12);  mode = M_SET; end
      5'd11: begin ma = cos_r[2]; mb = bk_r[B_SXCY]; tgt = 4'(B_R12); mode = M_SUB; end
      5'd12: begin ma = cos_r[0]; mb = sin_r[1]; tgt = 4'(B_R20);  mode = M_NEG; end
      5'd13: begin ma = cos_r[0]; mb = cos_r[1]; tgt = 4'(B_R22);  mode = M_SET; end
      default: begin ma = '0; mb = '0; tgt = 4'(B_R00); mode = M_SET; end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = !ph_r && ((state_r == S_POLY) || (state_r == S_MAT));
    mul_a  = '0;
    mul_b  = '0;
    if (state_r == S_POLY) begin
      case (op.kind)
        etrs_pkg::PK_XD: begin
          mul_a = etrs_pkg::MUL_A_W'(d_r);
          mul_b = etrs_pkg::DEG_RAD;
        end
        etrs_pkg::PK_X2: begin
          mul_a = etrs_pkg::MUL_A_W'(x_r);
          mul_b = etrs_pkg::MUL_B_W'(x_r);
        end
        etrs_pkg::PK_PM, etrs_pkg::PK_PM1: begin
          mul_a = etrs_pkg::MUL_A_W'(x2_r);
          mul_b = etrs_pkg::MUL_B_W'(op.one ? etrs_pkg::Q30_ONE : p_r);
        end
        etrs_pkg::PK_PD: begin
          mul_a = etrs_pkg::MUL_A_W'(v_r);
          mul_b = op.recip;
        end
        etrs_pkg::PK_SIN: begin
          mul_a = etrs_pkg::MUL_A_W'(x_r);
          mul_b = etrs_pkg::MUL_B_W'(p_r);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if (step_r < 5'd14) begin
      mul_a = etrs_pkg::MUL_A_W'(ma);
      mul_b = etrs_pkg::MUL_B_W'(mb);
    end else begin
      for (int k = 0; k < 9; k++) begin
        if (step_r == 5'(14 + k)) begin
          mul_a = etrs_pkg::MUL_A_W'(scl_r[k / 3]);
          mul_b = etrs_pkg::MUL_B_W'(bk_r[k]);
        end
      end
    end
  end

  // Product post-processing.
  always_comb begin
    t_q30    = prod[30 +: 30];
    t_div    = t_q30 >> op.shift;
    sin_sum  = prod[30 +: etrs_pkg::Q30_W] + etrs_pkg::Q30_HALF;
    cos_sum  = p_r + etrs_pkg::Q30_HALF;
    c_oct    = cos_sum[etrs_pkg::Q30_SH +: etrs_pkg::TRIG_W];
    prod_sum = prod + etrs_pkg::PROD_W'(longint'(1) << (etrs_pkg::FRAC_W - 1));
    rnd      = prod_sum[etrs_pkg::PROD_W-1:etrs_pkg::FRAC_W];
    rnd_rot  = rnd[etrs_pkg::ROT_W-1:0];
    case (mode)
      M_SET:   bk_new = rnd_rot;
      M_NEG:   bk_new = -rnd_rot;
      M_ADD:   bk_new = bk_r[tgt] + rnd_rot;
      M_SUB:   bk_new = bk_r[tgt] - rnd_rot;
      default: bk_new = rnd_rot;
    endcase
    if (swap_r) begin
      s0 = etrs_pkg::ROT_W'(c_oct);
      c0 = etrs_pkg::ROT_W'(s_oct_r);
    end else begin
      s0 = etrs_pkg::ROT_W'(s_oct_r);
      c0 = etrs_pkg::ROT_W'(c_oct);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ang_r       <= '0;
      step_r      <= '0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        scl_r[i] <= etrs_pkg::VALUE_W'(etrs_pkg::UNIT);
        rot_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            for (int i = 0; i < 3; i++) begin
              case (in_ch.command)
                etrs_pkg::CMD_SET_POS: pos_r[i] <= vec[i];
                etrs_pkg::CMD_ADD_POS:
                  pos_r[i] <= etrs_pkg::sat_val(64'(pos_r[i]) + 64'(vec[i]));
                etrs_pkg::CMD_SET_SCL: scl_r[i] <= vec[i];
                etrs_pkg::CMD_ADD_SCL:
                  scl_r[i] <= etrs_pkg::sat_val(64'(scl_r[i]) + 64'(vec[i]));
                etrs_pkg::CMD_SET_ROT: rot_r[i] <= vec[i];
                etrs_pkg::CMD_ADD_ROT:
                  rot_r[i] <= etrs_pkg::sat_val(64'(rot_r[i]) + 64'(vec[i]));
                default: ;
              endcase
            end
            ang_r   <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: state_r <= S_WRAP;
        S_WRAP: begin
          if (wrap_done) begin
            quad_r  <= quad;
            swap_r  <= swap;
            d_r     <= dsel[etrs_pkg::OCT_W-1:0];
            step_r  <= '0;
            ph_r    <= 1'b0;
            state_r <= S_POLY;
          end
        end
        S_POLY: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            case (op.kind)
              etrs_pkg::PK_XD:  x_r  <= prod[etrs_pkg::FRAC_W +: 30];
              etrs_pkg::PK_X2:  x2_r <= t_q30;
              etrs_pkg::PK_PM:  v_r  <= t_div;
              etrs_pkg::PK_PM1: p_r  <= etrs_pkg::Q30_ONE - etrs_pkg::Q30_W'(t_div);
              etrs_pkg::PK_PD:
                p_r <= etrs_pkg::Q30_ONE - prod[etrs_pkg::RECIP_SH +: etrs_pkg::Q30_W];
              etrs_pkg::PK_SIN: s_oct_r <= sin_sum[etrs_pkg::Q30_SH +: etrs_pkg::TRIG_W];
              default: ;
            endcase
            if (step_r == 5'(etrs_pkg::POLY_OPS - 1)) begin
              state_r <= S_FIN;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_FIN: begin
          case (quad_r)
            2'd0: begin sin_r[ang_r] <= s0;  cos_r[ang_r] <= c0;  end
            2'd1: begin sin_r[ang_r] <= c0;  cos_r[ang_r] <= -s0; end
            2'd2: begin sin_r[ang_r] <= -s0; cos_r[ang_r] <= -c0; end
            default: begin sin_r[ang_r] <= -c0; cos_r[ang_r] <= s0; end
          endcase
          if (ang_r == ANG_LAST) begin
            step_r  <= '0;
            ph_r    <= 1'b0;
            state_r <= S_MAT;
          end else begin
            ang_r   <= ang_r + 1'b1;
            state_r <= S_LOAD;
          end
        end
        S_MAT: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (step_r < 5'd14) begin
              bk_r[tgt] <= bk_new;
              if (step_r == 5'd0) begin
                bk_r[B_R21] <= sin_r[0];
              end
            end
            for (int k = 0; k < 9; k++) begin
              if (step_r == 5'(14 + k)) begin
                rowbuf_r[k / 3][k % 3] <= etrs_pkg::sat_val(64'(rnd));
              end
            end
            if (step_r == 5'(etrs_pkg::MAT_OPS - 1)) begin
              for (int i = 0; i < 3; i++) begin
                rowbuf_r[i][3] <= pos_r[i];
              end
              out_valid_r <= 1'b1;
              row_r       <= '0;
              state_r     <= S_OUT;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (row_r == ROW_LAST) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              row_r       <= row_r + 1'b1;
              rowbuf_r[0] <= rowbuf_r[1];
              rowbuf_r[1] <= rowbuf_r[2];
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  etrs_pkg::row_t out_row;
  assign out_row = (row_r == ROW_LAST) ? etrs_pkg::LAST_ROW : rowbuf_r[0];

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_index = row_r;
  assign out_ch.col_0     = out_row[0];
  assign out_ch.col_1     = out_row[1];
  assign out_ch.col_2     = out_row[2];
  assign out_ch.col_3     = out_row[3];
  assign out_ch.last_row  = (row_r == ROW_LAST);

  // A new item is never taken while rows of the previous one are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while rows are pending");

  // After the last row is taken the block is ready for the next item.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_row) |=> in_ch.ready)
    else $error("block not idle after last row");

  // Rows leave in order: a taken row that is not last is followed by the next.
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_row) |=>
      (out_ch.valid && (out_ch.row_index == $past(out_ch.row_index) + 2'd1)))
    else $error("row sequence broken");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for the TRS model matrix block
// Drives command items with random idle gaps and output stalls. A scoreboard
// class keeps its own position, scale and rotation state, predicts the four
// matrix rows of every item and checks each row field by field in order.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [1:0]   row_index;
    logic [31:0]  col[4];
    logic         last_row;
  } row_exp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   err_count = 0;
  int   row_count = 0;

  always #5 clk = ~clk;

  etrs_in_if  in_ch ();
  etrs_out_if out_ch ();

  euler_trs_model_matrix_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    err_count++;
  endtask

  function automatic longint clamp_val(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rounded Q16.16 product; operands stay small enough for 64-bit math
  // except scale, which is split into high and low parts.
  function automatic longint qmul(input longint a, input longint b);
    longint ah, al;
    ah = a >>> 16;
    al = a - (ah <<< 16);
    return ah * b + ((al * b + 32768) >>> 16);
  endfunction

  function automatic longint mq30(input longint unsigned a, input longint unsigned b);
    return longint'((a * b) >> 30);
  endfunction

  // Taylor series of sine and cosine for an angle in [0, 45] degrees.
  function automatic void octant_trig(input longint d, output longint s,
                                      output longint c);
    longint unsigned x, x2, p;
    x = (unsigned'(d) * 18740330) >> 16;
    x2 = mq30(x, x);
    p = 1 << 30;
    p = (1 << 30) - mq30(x2, p) / 72;
    p = (1 << 30) - mq30(x2, p) / 42;
    p = (1 << 30) - mq30(x2, p) / 20;
    p = (1 << 30) - mq30(x2, p) / 6;
    s = (mq30(x, p) + 8192) >> 14;
    p = 1 << 30;
    p = (1 << 30) - mq30(x2, p) / 90;
    p = (1 << 30) - mq30(x2, p) / 56;
    p = (1 << 30) - mq30(x2, p) / 30;
    p = (1 << 30) - mq30(x2, p) / 12;
    p = (1 << 30) - mq30(x2, p) / 2;
    c = (p + 8192) >> 14;
  endfunction

  function automatic void degree_trig(input longint ang, output longint s,
                                      output longint c);
    longint full_l, quarter_l, a, q, r, s0, c0;
    full_l = 360 * 65536;
    quarter_l = 90 * 65536;
    a = ((ang % full_l) + full_l) % full_l;
    q = a / quarter_l;
    r = a - q * quarter_l;
    if (r <= 45 * 65536) octant_trig(r, s0, c0);
    else octant_trig(quarter_l - r, c0, s0);
    case (q)
      0: begin s = s0; c = c0; end
      1: begin s = c0; c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  class matrix_scoreboard;
    longint   position[3];
    longint   scale[3];
    longint   rotation[3];
    row_exp_t pending_rows[$];

    function new();
      for (int i = 0; i < 3; i++) begin
        position[i] = 0;
        scale[i] = 65536;
        rotation[i] = 0;
      end
    endfunction

    function void note_command(input logic [2:0] cmd, input logic signed [31:0] vx,
                               input logic signed [31:0] vy,
                               input logic signed [31:0] vz);
      longint v[3];
      longint sx, cx, sy, cy, sz, cz, sxsy, sxcy;
      longint rm[3][3];
      row_exp_t r;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      for (int i = 0; i < 3; i++) begin
        case (cmd)
          etrs_pkg::CMD_SET_POS: position[i] = v[i];
          etrs_pkg::CMD_ADD_POS: position[i] = clamp_val(position[i] + v[i]);
          etrs_pkg::CMD_SET_SCL: scale[i] = v[i];
          etrs_pkg::CMD_ADD_SCL: scale[i] = clamp_val(scale[i] + v[i]);
          etrs_pkg::CMD_SET_ROT: rotation[i] = v[i];
          etrs_pkg::CMD_ADD_ROT: rotation[i] = clamp_val(rotation[i] + v[i]);
          default: ;
        endcase
      end
      degree_trig(rotation[0], sx, cx);
      degree_trig(rotation[1], sy, cy);
      degree_trig(rotation[2], sz, cz);
      sxsy = qmul(sx, sy);
      sxcy = qmul(sx, cy);
      rm[0][0] = qmul(cz, cy) - qmul(sz, sxsy);
      rm[0][1] = -qmul(sz, cx);
      rm[0][2] = qmul(cz, sy) + qmul(sz, sxcy);
      rm[1][0] = qmul(sz, cy) + qmul(cz, sxsy);
      rm[1][1] = qmul(cz, cx);
      rm[1][2] = qmul(sz, sy) - qmul(cz, sxcy);
      rm[2][0] = -qmul(cx, sy);
      rm[2][1] = sx;
      rm[2][2] = qmul(cx, cy);
      for (int i = 0; i < 4; i++) begin
        r.row_index = i[1:0];
        r.last_row = (i == 3);
        if (i < 3) begin
          for (int j = 0; j < 3; j++) r.col[j] = 32'(clamp_val(qmul(scale[i], rm[i][j])));
          r.col[3] = 32'(position[i]);
        end else begin
          r.col[0] = '0;
          r.col[1] = '0;
          r.col[2] = '0;
          r.col[3] = 32'h0001_0000;
        end
        pending_rows = {pending_rows, r};
      end
    endfunction

    task check_row(input logic [1:0] idx, input logic [31:0] c0,
                   input logic [31:0] c1, input logic [31:0] c2,
                   input logic [31:0] c3, input logic last);
      row_exp_t e;
      logic [31:0] got[4];
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row %0d", idx));
        return;
      end
      e = pending_rows.pop_front();
      got[0] = c0;
      got[1] = c1;
      got[2] = c2;
      got[3] = c3;
      if (idx !== e.row_index)
        report_mismatch($sformatf("row_index %0d, want %0d", idx, e.row_index));
      for (int j = 0; j < 4; j++)
        if (got[j] !== e.col[j])
          report_mismatch($sformatf("row %0d col_%0d %h, want %h", e.row_index, j,
                                    got[j], e.col[j]));
      if (last !== e.last_row)
        report_mismatch($sformatf("row %0d last_row %b", e.row_index, last));
    endtask
  endclass

  matrix_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.vec_z = '0;
    out_ch.ready = 1'b0;
  end

  // Output stalls change at the falling edge.
  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_row(out_ch.row_index, out_ch.col_0, out_ch.col_1, out_ch.col_2,
                   out_ch.col_3, out_ch.last_row);
      row_count++;
    end

  // Called at a falling edge; returns at the falling edge after the item is
  // taken with valid still high, so the next call or the caller drops it.
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] vx,
                              input logic [31:0] vy, input logic [31:0] vz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.vec_x <= vx;
    in_ch.vec_y <= vy;
    in_ch.vec_z <= vz;
    // Ready only moves at a rising edge, so it is stable here.
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sb.note_command(cmd, vx, vy, vz);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(720)) - 360) <<< 16;
      2: return 32'(($urandom_range(8) * 45) <<< 16) + 32'($urandom_range(3)) - 1;
      default: return 32'($signed($urandom_range(47185920)) - 23592960);
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(655360)) - 327680);
      2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  task automatic random_items(input int n);
    logic [2:0] cmd;
    for (int k = 0; k < n; k++) begin
      cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                      : 3'($urandom_range(5));
      if (cmd == etrs_pkg::CMD_SET_ROT || cmd == etrs_pkg::CMD_ADD_ROT)
        send_command(cmd, rand_angle(), rand_angle(), rand_angle());
      else
        send_command(cmd, rand_value(), rand_value(), rand_value());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: reset matrix, each command, quadrant edges, extremes, unknown codes.
    send_command(etrs_pkg::CMD_SET_POS, 32'h0001_0000, 32'hfffe_0000, 32'h0000_8000);
    send_command(etrs_pkg::CMD_ADD_POS, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_command(etrs_pkg::CMD_ADD_POS, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_command(etrs_pkg::CMD_SET_SCL, 32'h0002_0000, 32'h0000_8000, 32'hffff_0000);
    send_command(etrs_pkg::CMD_ADD_SCL, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_command(etrs_pkg::CMD_SET_SCL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_command(etrs_pkg::CMD_SET_ROT, 32'h005a_0000, 32'h00b4_0000, 32'h010e_0000);
    send_command(etrs_pkg::CMD_SET_ROT, 32'h002d_0000, 32'h002d_0001, 32'h002c_ffff);
    send_command(etrs_pkg::CMD_SET_ROT, 32'h0168_0000, 32'hffa6_0000, 32'hfe98_0000);
    send_command(etrs_pkg::CMD_SET_ROT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_command(etrs_pkg::CMD_ADD_ROT, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_command(etrs_pkg::CMD_SET_SCL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_command(etrs_pkg::CMD_SET_ROT, 32'h001e_0000, 32'h003c_0000, 32'h0087_0000);
    send_command(etrs_pkg::CMD_ADD_ROT, 32'h0005_8000, 32'hfff6_0000, 32'h0000_0000);
    send_command(3'd6, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff);
    send_command(3'd7, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
    // Random phases with varying idle and stall rates.
    random_items(36);
    send_idle_pct = 79;
    random_items(36);
    send_idle_pct = 0;
    stall_pct = 79;
    random_items(36);
    send_idle_pct = 9;
    stall_pct = 9;
    random_items(36);
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("tb: checked %0d matrix rows from about 160 command items,", row_count);
    $display("tb: all six commands, unknown codes, angle wraps and saturation.");
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Slowest run: ~160 items, each a matrix build and 4 rows under heavy stall,
  // ends far below this bound.
  initial begin
    #20ms;
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end
endmodule
